// ===== hw/rtl/cdq_pkg.sv =====
package cdq_pkg;

   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;
   localparam int ADDR_W   = 3;
   localparam int CSR_W    = 32;

   // commands
   localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // register map: word index sits in paddr[2]
   localparam int          REG_IDX_BIT  = 2;
   localparam logic        REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
      logic clear;
   } cdq_op_type;

   typedef struct packed {
      logic              occ;
      logic [DATA_W-1:0] data;
   } cdq_cell_type;

endpackage

// ===== hw/rtl/cdq_cell.sv =====
module cdq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cdq_pkg::cdq_op_type   op,
   input  logic [cdq_pkg::DATA_W-1:0] value,
   input  cdq_pkg::cdq_cell_type left_q,
   input  cdq_pkg::cdq_cell_type right_q,
   output cdq_pkg::cdq_cell_type cell_q,
   output cdq_pkg::cdq_cell_type cell_d
);
   import cdq_pkg::*;

   logic              occ_ff;
   logic              occ_in;
   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      priority if (op.clear) begin
         occ_in = 1'b0;
      end else if (op.push_front) begin
         // whole row shifts one place toward the rear
         data_in = left_q.data;
         occ_in  = left_q.occ;
      end else if (op.push_rear) begin
         // first free cell takes the value
         if (!occ_ff && left_q.occ) begin
            data_in = value;
            occ_in  = 1'b1;
         end
      end else if (op.pop_front) begin
         data_in = right_q.data;
         occ_in  = right_q.occ;
      end else if (op.pop_rear) begin
         occ_in = occ_ff & right_q.occ;
      end else begin
         occ_in = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_q = '{occ: occ_ff, data: data_ff};
   assign cell_d = '{occ: occ_in, data: data_in};

endmodule

// ===== hw/rtl/circular_double_ended_queue.sv =====
// Double-ended queue of up to DEPTH 32-bit entries, usable capacity set by the
// capacity register (0 acts as 1, values above DEPTH act as DEPTH; a write
// empties the queue). Each request beat carries a command (peek, push front,
// push rear, pop front, pop rear; unknown codes act as peek) and a value, and
// yields exactly one response beat with status, front/rear entries, and the
// empty/full flags. Throughput is one request per cycle: the entries live in
// a row of cells that all shift or load in the same clock, and the response
// is registered and appears in the cycle after the request is taken. The
// request side stalls only while a response is held by a stalled consumer.
// No clearing pass after reset; the queue is usable at once.
module circular_double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cdq_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [cdq_pkg::DATA_W-1:0]  req_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cdq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_rear_value,
   output logic                               rsp_ends_valid,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cdq_pkg::ADDR_W-1:0]         paddr,
   input  logic [cdq_pkg::CSR_W-1:0]          pwdata,
   output logic [cdq_pkg::CSR_W-1:0]          prdata,
   output logic                               pready
);
   import cdq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   // ---------------------------------------------------------------
   // Capacity register
   // ---------------------------------------------------------------
   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready
                 & (paddr[REG_IDX_BIT] == REG_CAPACITY);
   assign cap_in = cfg_wr ? pwdata[CAP_W-1:0] : cap_ff;
   assign prdata = (paddr[REG_IDX_BIT] == REG_CAPACITY) ? CSR_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // effective capacity, clamped to 1..DEPTH
   logic [CMP_W-1:0] cap_wide;
   logic [CMP_W-1:0] cap_use;

   assign cap_wide = CMP_W'(cap_ff);
   assign cap_use  = (cap_wide == '0) ? CMP_W'(1) :
                     ((cap_wide > DEPTH_C) ? DEPTH_C : cap_wide);

   // ---------------------------------------------------------------
   // Handshake and command decode
   // ---------------------------------------------------------------
   logic                rsp_valid_ff;
   logic                accept;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic                full_now;
   logic                empty_now;
   cdq_op_type          op;
   logic [STATUS_W-1:0] status_in;

   // a held response blocks the next request only while the consumer stalls
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full_now  = (CMP_W'(cnt_ff) == cap_use);
   assign empty_now = (cnt_ff == '0);

   always_comb begin
      op        = '0;
      status_in = ST_OK;
      op.clear  = cfg_wr;
      if (accept) begin
         unique case (req_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
               if (full_now) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  op.push_front = (req_cmd == CMD_PUSH_FRONT);
                  op.push_rear  = (req_cmd == CMD_PUSH_REAR);
               end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
               if (empty_now) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  op.pop_front = (req_cmd == CMD_POP_FRONT);
                  op.pop_rear  = (req_cmd == CMD_POP_REAR);
               end
            end
            default: begin
               // peek and unused codes: no state change
               status_in = ST_OK;
            end
         endcase
      end
   end

   // entry count mirrors the occupied prefix of the cell row
   always_comb begin
      priority if (op.clear) begin
         cnt_in = '0;
      end else if (op.push_front || op.push_rear) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (op.pop_front || op.pop_rear) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // ---------------------------------------------------------------
   // Cell row: cell 0 is the front, occupied cells form a prefix.
   // Push front shifts toward the rear, pop front shifts toward the
   // front, rear ops touch only the boundary cell.
   // ---------------------------------------------------------------
   cdq_cell_type      cell_q [DEPTH];
   cdq_cell_type      cell_d [DEPTH];
   logic [DEPTH:0]    occ_d;
   logic [DEPTH-1:0]  occ_q;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cdq_cell_type left_q;
      cdq_cell_type right_q;

      if (i == 0) begin : g_first
         // ahead of the front: always "occupied", carries the new value
         assign left_q = '{occ: 1'b1, data: req_value};
      end else begin : g_mid_l
         assign left_q = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_q = '{occ: 1'b0, data: '0};
      end else begin : g_mid_r
         assign right_q = cell_q[i+1];
      end

      cdq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .op      (op),
         .value   (req_value),
         .left_q  (left_q),
         .right_q (right_q),
         .cell_q  (cell_q[i]),
         .cell_d  (cell_d[i])
      );

      assign occ_d[i] = cell_d[i].occ;
      assign occ_q[i] = cell_q[i].occ;
   end
   assign occ_d[DEPTH] = 1'b0;

   // rear entry: the last occupied cell after this beat's update
   logic [DATA_W-1:0] rear_pick;

   always_comb begin
      rear_pick = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (occ_d[i] && !occ_d[i+1]) begin
            rear_pick = rear_pick | cell_d[i].data;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   logic [STATUS_W-1:0] status_ff;
   logic [DATA_W-1:0]   front_ff;
   logic [DATA_W-1:0]   rear_ff;
   logic                ends_ff;
   logic                empty_ff;
   logic                full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         front_ff  <= occ_d[0] ? cell_d[0].data : '0;
         rear_ff   <= rear_pick;
         ends_ff   <= occ_d[0];
         empty_ff  <= (cnt_in == '0);
         full_ff   <= (CMP_W'(cnt_in) == cap_use);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_front_value = front_ff;
   assign rsp_rear_value  = rear_ff;
   assign rsp_ends_valid  = ends_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // counter agrees with the number of occupied cells
   a_cnt_match: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_q) == int'(cnt_ff))
      else $error("entry count disagrees with cell occupancy");

   // count never exceeds the capacity in use
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(cnt_ff) <= cap_use)
      else $error("entry count above capacity");

   // overflow only reported against a full queue
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_OVERFLOW) |-> full_ff)
      else $error("overflow reported while not full");

   // underflow only reported against an empty queue
   a_unf_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_UNDERFLOW) |-> empty_ff && !ends_ff)
      else $error("underflow reported while not empty");

   // a successful push always leaves at least one entry
   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      (op.push_front || op.push_rear) && !op.clear |=> !empty_now)
      else $error("queue empty after push");

endmodule
